/* sv/asfq_pkg.sv */
`timescale 1ns / 1ps
package asfq_pkg;

	// pipeline depth: input register, five arithmetic stages, two slot-state
	// stages and the result register
	localparam int NUM_STAGES = 9;

	// configuration port address width, one 32-bit word per register
	localparam int PADDR_W = 4;

	// register reset values
	localparam logic [15:0] ERROR_THRESHOLD_RST = 16'd1000;
	localparam logic [15:0] ERROR_CEILING_RST   = 16'd10000;
	localparam logic [7:0]  PENALTY_LENGTH_RST  = 8'd10;
	localparam logic [30:0] RAMP_LIMIT_RST      = 31'd256000;

	// register word indexes
	typedef enum logic [1:0] {
		REG_ERROR_THRESHOLD = 2'd0,
		REG_ERROR_CEILING   = 2'd1,
		REG_PENALTY_LENGTH  = 2'd2,
		REG_RAMP_LIMIT      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] error_threshold;
		logic [15:0] error_ceiling;
		logic [7:0]  penalty_length;
		logic [30:0] ramp_limit;
	} cfg_t;

	// sensor update item
	typedef struct packed {
		logic [1:0]         slot;
		logic               reading_valid;
		logic               armed;
		logic signed [31:0] reading_cm;
		logic signed [31:0] sensor_velocity;
		logic signed [31:0] accel_velocity;
		logic signed [31:0] fused_estimate;
	} sensor_item_t;

	// result item
	typedef struct packed {
		logic               fuse_now;
		logic signed [31:0] measurement_cm;
		logic [15:0]        velocity_error;
		logic signed [31:0] zero_offset;
	} result_item_t;

	// per-stage load enables and occupancy
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} stage_ctrl_t;

	// fields carried along the whole pipeline
	typedef struct packed {
		logic [1:0]         slot;
		logic               reading_valid;
		logic               armed;
		logic signed [31:0] reading_cm;
	} meta_t;

	// front end result: squared velocity difference split for the /100
	typedef struct packed {
		meta_t              meta;
		logic signed [32:0] tgt;
		logic signed [46:0] rdw;
		logic signed [43:0] tgw;
		logic               big;
		logic [62:0]        lp;
		logic [28:0]        qw;
	} front_t;

	// after the velocity error update
	typedef struct packed {
		meta_t              meta;
		logic               inr;
		logic signed [32:0] tgt;
		logic signed [46:0] rdw;
		logic signed [43:0] tgw;
		logic [15:0]        ve;
	} vel_t;

	// after the penalty and offset update
	typedef struct packed {
		logic               inr;
		logic               fuse;
		logic signed [31:0] reading_cm;
		logic signed [31:0] off;
		logic [15:0]        ve;
	} off_item_t;

	// clamp to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
		logic signed [31:0] r;
		if (x > 36'sh0_7fff_ffff) begin
			r = 32'sh7fff_ffff;
		end else if (x < 36'shf_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

/* sv/altitude_sensor_fusion_qualifier_unit.sv */
`timescale 1ns / 1ps
// Altitude sensor fusion qualifier. Each sensor item updates the velocity error,
// penalty countdown, zero offset and offset error of its slot and gives one result
// item: whether the reading may be fused, the offset-corrected measurement, the
// averaged velocity error and the zero offset. The block takes one item per clock
// while the output is not stalled; its pipeline holds the squaring multiply, the
// two-step reciprocal division by 100 and the two slot-state stages, each of which
// reads and writes its slot state within its own stage so that updates for the
// same slot can follow each other directly. Slot state clears at reset. Registers
// are written over the APB port with no wait states; the user must write them only
// while the block holds no item, which the block itself does not enforce.
module altitude_sensor_fusion_qualifier_unit
	import asfq_pkg::*;
#(
	parameter int SENSOR_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sensor_valid,
	output logic               sensor_stall,
	input  sensor_item_t       sensor,
	output logic               result_valid,
	input  logic               result_stall,
	output result_item_t       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t         cfg;
	stage_ctrl_t  ctrl;
	front_t       front;
	vel_t         vel;
	off_item_t    off_item;
	result_item_t result_q;

	logic signed [31:0] rd, off;

	asfq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asfq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sensor_valid (sensor_valid),
		.sensor_stall (sensor_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctrl         (ctrl)
	);

	asfq_front u_front (
		.clk    (clk),
		.sensor (sensor),
		.ctrl   (ctrl),
		.front  (front)
	);

	asfq_vel #(
		.SENSOR_SLOTS (SENSOR_SLOTS)
	) u_vel (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.ctrl   (ctrl),
		.cfg    (cfg),
		.vel    (vel)
	);

	asfq_offset #(
		.SENSOR_SLOTS (SENSOR_SLOTS)
	) u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.vel      (vel),
		.ctrl     (ctrl),
		.cfg      (cfg),
		.off_item (off_item)
	);

	assign rd  = off_item.reading_cm;
	assign off = off_item.off;

	// result register, slots beyond the store report zero
	always_ff @(posedge clk) begin
		if (ctrl.load[NUM_STAGES-1]) begin
			if (off_item.inr) begin
				result_q.fuse_now       <= off_item.fuse;
				result_q.measurement_cm <= sat32(36'(rd) - 36'(off));
				result_q.velocity_error <= off_item.ve;
				result_q.zero_offset    <= off;
			end else begin
				result_q <= '0;
			end
		end
	end

	assign result = result_q;

endmodule

/* sv/asfq_regs.sv */
`timescale 1ns / 1ps
module asfq_regs
	import asfq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	reg_idx_t idx;
	cfg_t     cfg_q;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_threshold <= ERROR_THRESHOLD_RST;
			cfg_q.error_ceiling   <= ERROR_CEILING_RST;
			cfg_q.penalty_length  <= PENALTY_LENGTH_RST;
			cfg_q.ramp_limit      <= RAMP_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_ERROR_THRESHOLD: cfg_q.error_threshold <= pwdata[15:0];
				REG_ERROR_CEILING:   cfg_q.error_ceiling   <= pwdata[15:0];
				REG_PENALTY_LENGTH:  cfg_q.penalty_length  <= pwdata[7:0];
				REG_RAMP_LIMIT:      cfg_q.ramp_limit      <= pwdata[30:0];
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_ERROR_THRESHOLD: prdata = {16'd0, cfg_q.error_threshold};
			REG_ERROR_CEILING:   prdata = {16'd0, cfg_q.error_ceiling};
			REG_PENALTY_LENGTH:  prdata = {24'd0, cfg_q.penalty_length};
			REG_RAMP_LIMIT:      prdata = {1'b0, cfg_q.ramp_limit};
		endcase
	end

endmodule

/* sv/asfq_ctrl.sv */
`timescale 1ns / 1ps
module asfq_ctrl
	import asfq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sensor_valid,
	output logic        sensor_stall,
	output logic        result_valid,
	input  logic        result_stall,
	output stage_ctrl_t ctrl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] free;
	logic [NUM_STAGES-1:0] prev;

	// a stage may load when it is empty or its item moves on
	always_comb begin
		free[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || !result_stall;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			free[k] = !vld_q[k] || free[k+1];
		end
	end

	assign prev = {vld_q[NUM_STAGES-2:0], sensor_valid};

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (free & prev) | (~free & vld_q);
		end
	end

	assign ctrl.load    = free;
	assign ctrl.valid   = vld_q;
	assign sensor_stall = !free[0];
	assign result_valid = vld_q[NUM_STAGES-1];

	// an empty slot anywhere lets the next item in
	a_bubble_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_q) |-> !sensor_stall)
		else $error("input stalled with a bubble in the pipeline");

	// an accepted item lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(sensor_valid && !sensor_stall) |=> vld_q[0])
		else $error("accepted item lost at the input register");

	// the last stage drains into a free result register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NUM_STAGES-2] && !result_stall) |=> result_valid)
		else $error("item lost ahead of the result register");

endmodule

/* sv/asfq_front.sv */
`timescale 1ns / 1ps
module asfq_front
	import asfq_pkg::*;
(
	input  logic         clk,
	input  sensor_item_t sensor,
	input  stage_ctrl_t  ctrl,
	output front_t       front
);

	// reciprocals of 100 for the two halves of the long division
	localparam logic [23:0] M_HI = 24'd10737419;    // ceil(2^30/100)
	localparam logic [31:0] M_LO = 32'd2748779070;  // ceil(2^38/100)

	sensor_item_t in_s1;

	meta_t              meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;
	logic [31:0]        mag_s2;
	logic signed [32:0] tgt_s2, tgt_s3, tgt_s4, tgt_s5, tgt_s6;
	logic signed [46:0] rdw_s2, rdw_s3, rdw_s4, rdw_s5, rdw_s6;
	logic [63:0]        sq_s3;
	logic signed [43:0] tgw_s3, tgw_s4, tgw_s5, tgw_s6;
	logic               big_s4, big_s5, big_s6;
	logic [46:0]        hp_s4;
	logic [22:0]        hi_s4;
	logic [23:0]        lo_s4;
	logic [30:0]        t_s5;
	logic [15:0]        qhi_s5;
	logic [62:0]        lp_s6;
	logic [28:0]        qw_s6;

	logic signed [31:0] rd, sv, av, fe;
	logic signed [32:0] vdiff, vneg, tgt;
	logic [15:0]        qhi;
	logic [22:0]        rprod, rdiff;

	// input register
	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			in_s1 <= sensor;
		end
	end

	// velocity difference magnitude, offset target, reading blend term
	assign rd    = in_s1.reading_cm;
	assign sv    = in_s1.sensor_velocity;
	assign av    = in_s1.accel_velocity;
	assign fe    = in_s1.fused_estimate;
	assign vdiff = 33'(av) - 33'(sv);
	assign vneg  = -vdiff;
	assign tgt   = 33'(rd) - 33'(fe);

	always_ff @(posedge clk) begin
		if (ctrl.load[1]) begin
			meta_s2.slot          <= in_s1.slot;
			meta_s2.reading_valid <= in_s1.reading_valid;
			meta_s2.armed         <= in_s1.armed;
			meta_s2.reading_cm    <= in_s1.reading_cm;
			mag_s2                <= vdiff[32] ? vneg[31:0] : vdiff[31:0];
			tgt_s2                <= tgt;
			rdw_s2                <= 47'(rd) * 47'sd13107;
		end
	end

	// square, and target times 0.01
	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			meta_s3 <= meta_s2;
			sq_s3   <= 64'(mag_s2) * 64'(mag_s2);
			tgt_s3  <= tgt_s2;
			rdw_s3  <= rdw_s2;
			tgw_s3  <= 44'(tgt_s2) * 44'sd655;
		end
	end

	// overflow check, quotient of the upper bits by 100
	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			meta_s4 <= meta_s3;
			tgt_s4  <= tgt_s3;
			rdw_s4  <= rdw_s3;
			tgw_s4  <= tgw_s3;
			big_s4  <= sq_s3[63:40] >= 24'd100;
			hi_s4   <= sq_s3[46:24];
			hp_s4   <= 47'(sq_s3[46:24]) * 47'(M_HI);
			lo_s4   <= sq_s3[23:0];
		end
	end

	// remainder of the upper bits, joined with the lower bits
	assign qhi   = hp_s4[45:30];
	assign rprod = 23'(qhi) * 23'd100;
	assign rdiff = hi_s4 - rprod;

	always_ff @(posedge clk) begin
		if (ctrl.load[4]) begin
			meta_s5 <= meta_s4;
			tgt_s5  <= tgt_s4;
			rdw_s5  <= rdw_s4;
			tgw_s5  <= tgw_s4;
			big_s5  <= big_s4;
			qhi_s5  <= qhi;
			t_s5    <= {rdiff[6:0], lo_s4};
		end
	end

	// quotient of the lower part, upper quotient times 0.1
	always_ff @(posedge clk) begin
		if (ctrl.load[5]) begin
			meta_s6 <= meta_s5;
			tgt_s6  <= tgt_s5;
			rdw_s6  <= rdw_s5;
			tgw_s6  <= tgw_s5;
			big_s6  <= big_s5;
			lp_s6   <= 63'(t_s5) * 63'(M_LO);
			qw_s6   <= 29'(qhi_s5) * 29'd6554;
		end
	end

	assign front.meta = meta_s6;
	assign front.tgt  = tgt_s6;
	assign front.rdw  = rdw_s6;
	assign front.tgw  = tgw_s6;
	assign front.big  = big_s6;
	assign front.lp   = lp_s6;
	assign front.qw   = qw_s6;

endmodule

/* sv/asfq_vel.sv */
`timescale 1ns / 1ps
module asfq_vel
	import asfq_pkg::*;
#(
	parameter int SENSOR_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  front_t      front,
	input  stage_ctrl_t ctrl,
	input  cfg_t        cfg,
	output vel_t        vel
);

	localparam int IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

	logic [15:0] vel_q [SENSOR_SLOTS];

	logic [IDX_W-1:0] idx;
	logic             inr, upd, wr;
	logic [15:0]      old, ve_new, ve;
	logic [23:0]      qlo;
	logic [36:0]      qlo_w;
	logic [31:0]      old_w;
	logic [53:0]      acc;
	logic [21:0]      r;
	vel_t             vel_s7;

	assign idx = IDX_W'(front.meta.slot);
	assign inr = 32'(front.meta.slot) < SENSOR_SLOTS;
	assign upd = front.meta.reading_valid && inr;
	assign wr  = ctrl.load[6] && ctrl.valid[5] && upd;
	assign old = vel_q[idx];

	// 0.1 * squared difference / 100 + 0.9 * old error, integer part
	assign qlo    = front.lp[61:38];
	assign qlo_w  = 37'(qlo) * 37'd6554;
	assign old_w  = 32'(old) * 32'd58982;
	assign acc    = 54'({front.qw, 24'd0}) + 54'(qlo_w) + 54'({old_w, 16'd0});
	assign r      = acc[53:32];
	assign ve_new = (front.big || r > 22'(cfg.error_ceiling)) ? cfg.error_ceiling : r[15:0];
	assign ve     = upd ? ve_new : old;

	// per-slot error store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_SLOTS; i++) begin
				vel_q[i] <= '0;
			end
		end else if (wr) begin
			vel_q[idx] <= ve_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[6]) begin
			vel_s7.meta <= front.meta;
			vel_s7.inr  <= inr;
			vel_s7.tgt  <= front.tgt;
			vel_s7.rdw  <= front.rdw;
			vel_s7.tgw  <= front.tgw;
			vel_s7.ve   <= ve;
		end
	end

	assign vel = vel_s7;

endmodule

/* sv/asfq_offset.sv */
`timescale 1ns / 1ps
module asfq_offset
	import asfq_pkg::*;
#(
	parameter int SENSOR_SLOTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  vel_t        vel,
	input  stage_ctrl_t ctrl,
	input  cfg_t        cfg,
	output off_item_t   off_item
);

	localparam int IDX_W = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

	logic [7:0]         pen_q  [SENSOR_SLOTS];
	logic signed [31:0] off_q  [SENSOR_SLOTS];
	logic signed [31:0] ramp_q [SENSOR_SLOTS];

	logic [IDX_W-1:0]   idx;
	logic               upd, wr, ramp_wr, armed, fuse_new, over;
	logic [7:0]         pen_old, pen_new;
	logic signed [31:0] off_old, ramp_old, off_new, ramp_sat, ramp_dec, ramp_new;
	logic signed [32:0] tgt, ramp_ext, ramp_neg;
	logic signed [46:0] rdw;
	logic signed [43:0] tgw;
	logic signed [16:0] coef;
	logic signed [48:0] offw;
	logic signed [49:0] blend;
	logic signed [33:0] hsum;
	logic signed [34:0] rsum;
	logic [31:0]        rabs, rdq;
	logic [47:0]        rdec;
	logic               rneg, ramp_hit;
	off_item_t          off_s8;

	assign idx      = IDX_W'(vel.meta.slot);
	assign upd      = vel.meta.reading_valid && vel.inr;
	assign armed    = vel.meta.armed;
	assign pen_old  = pen_q[idx];
	assign off_old  = off_q[idx];
	assign ramp_old = ramp_q[idx];
	assign tgt      = vel.tgt;
	assign rdw      = vel.rdw;
	assign tgw      = vel.tgw;

	// penalty countdown
	assign over     = vel.ve > cfg.error_threshold;
	assign pen_new  = over ? cfg.penalty_length :
		((pen_old != 8'd0) ? pen_old - 8'd1 : 8'd0);
	assign fuse_new = pen_new == 8'd0;

	// blend: 0.2/0.8 with the reading when disarmed, 0.01/0.99 with the target when armed
	assign coef  = armed ? 17'sd64881 : 17'sd52429;
	assign offw  = 49'(off_old) * 49'(coef);
	assign blend = 50'(offw) + (armed ? 50'(tgw) : 50'(rdw));

	// halfway step toward the target, rounding down
	assign hsum = 34'(tgt) + 34'(off_old);

	// accumulated offset error with 0.99 decay rounding toward zero
	assign rsum     = 35'(ramp_old) + 35'(tgt) - 35'(off_old);
	assign ramp_sat = sat32(36'(rsum));
	assign rneg     = ramp_sat[31];
	assign ramp_ext = 33'(ramp_sat);
	assign ramp_neg = -ramp_ext;
	assign rabs     = rneg ? ramp_neg[31:0] : ramp_ext[31:0];
	assign ramp_hit = rabs > {1'b0, cfg.ramp_limit};
	assign rdec     = 48'(rabs) * 48'd64881;
	assign rdq      = rdec[47:16];
	assign ramp_dec = rneg ? -$signed(rdq) : $signed(rdq);
	assign ramp_new = ramp_hit ? ramp_dec : ramp_sat;

	// new zero offset
	always_comb begin
		priority if (!armed) begin
			off_new = sat32(36'($signed(blend[49:16])));
		end else if (!fuse_new) begin
			off_new = sat32(36'($signed(hsum[33:1])));
		end else if (ramp_hit) begin
			off_new = sat32(36'($signed(blend[49:16])));
		end else begin
			off_new = off_old;
		end
	end

	assign wr      = ctrl.load[7] && ctrl.valid[6] && upd;
	assign ramp_wr = wr && armed && fuse_new;

	// per-slot stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SENSOR_SLOTS; i++) begin
				pen_q[i]  <= '0;
				off_q[i]  <= '0;
				ramp_q[i] <= '0;
			end
		end else begin
			if (wr) begin
				pen_q[idx] <= pen_new;
				off_q[idx] <= off_new;
			end
			if (ramp_wr) begin
				ramp_q[idx] <= ramp_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[7]) begin
			off_s8.inr        <= vel.inr;
			off_s8.fuse       <= upd && fuse_new;
			off_s8.reading_cm <= vel.meta.reading_cm;
			off_s8.off        <= upd ? off_new : off_old;
			off_s8.ve         <= vel.ve;
		end
	end

	assign off_item = off_s8;

endmodule

/* dv/altitude_sensor_fusion_qualifier_unit_tb.sv */
`timescale 1ns / 1ps
module altitude_sensor_fusion_qualifier_unit_tb
	import asfq_pkg::*;
;

	localparam int SLOTS = 4;
	localparam int TIMEOUT_NS = 2_000_000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic [30:0] RAMP_MAX = 31'h7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sensor_valid = 1'b0;
	logic sensor_stall;
	sensor_item_t sensor_item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_item_t result_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// shadow registers and per-slot state of the qualifier
	logic [15:0] shadow_threshold;
	logic [15:0] shadow_ceiling;
	logic [7:0] shadow_penalty_len;
	logic [30:0] shadow_ramp_limit;
	logic [15:0] slot_vel_error [SLOTS];
	logic [7:0] slot_penalty [SLOTS];
	logic signed [31:0] slot_offset [SLOTS];
	logic signed [31:0] slot_ramp_error [SLOTS];

	result_item_t fusion_results_due [$];
	result_item_t want;
	int slot_drift [SLOTS] = '{default: 0};
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int burst_left = 0;
	int stall_cycle = 0;
	int stall_mode = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	altitude_sensor_fusion_qualifier_unit #(
		.SENSOR_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sensor_valid(sensor_valid),
		.sensor_stall(sensor_stall),
		.sensor(sensor_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_item),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// clamp to the 32-bit signed range
	function automatic logic signed [31:0] clamp_s32(input longint v);
		if (v > longint'(S32_MAX)) begin
			return S32_MAX;
		end
		if (v < longint'(S32_MIN)) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

	// averaged squared velocity difference over 100, clamped to the ceiling
	function automatic logic [15:0] averaged_vel_error(input logic [15:0] old,
			input logic signed [31:0] accel_vel, input logic signed [31:0] sens_vel);
		longint d;
		logic [63:0] mag;
		logic [63:0] sq;
		logic [63:0] blend;
		logic [63:0] r;
		d = longint'(accel_vel) - longint'(sens_vel);
		mag = (d < 0) ? -d : d;
		sq = (mag * mag) / 64'd100;
		if (sq >= (64'd1 << 40)) begin
			r = 64'(shadow_ceiling);
		end else begin
			blend = sq * 64'd6554 + (({48'd0, old} * 64'd58982) << 16);
			r = blend >> 32;
		end
		if (r > 64'(shadow_ceiling)) begin
			r = 64'(shadow_ceiling);
		end
		return r[15:0];
	endfunction

	// one sensor update: refresh the slot and form its result item
	function automatic result_item_t qualify_update(input sensor_item_t it);
		result_item_t r;
		int s;
		longint rd;
		longint fe;
		longint off;
		longint tgt;
		longint ramp;
		longint mag;
		logic fuse;
		s = int'(it.slot);
		fuse = 1'b0;
		rd = $signed(it.reading_cm);
		fe = $signed(it.fused_estimate);
		if (it.reading_valid) begin
			slot_vel_error[s] = averaged_vel_error(slot_vel_error[s], it.accel_velocity,
				it.sensor_velocity);
			if (slot_vel_error[s] > shadow_threshold) begin
				slot_penalty[s] = shadow_penalty_len;
			end else if (slot_penalty[s] != 8'd0) begin
				slot_penalty[s] = slot_penalty[s] - 8'd1;
			end
			fuse = (slot_penalty[s] == 8'd0);
			off = slot_offset[s];
			if (!it.armed) begin
				// disarmed: 0.2 reading, 0.8 old offset
				off = (rd * 13107 + off * 52429) >>> 16;
			end else begin
				tgt = rd - fe;
				if (slot_penalty[s] != 8'd0) begin
					// penalised: halfway toward the new offset
					off = (tgt + off) >>> 1;
				end else begin
					// ramp detection on the accumulated offset error
					ramp = clamp_s32(longint'(slot_ramp_error[s]) + (tgt - off));
					mag = (ramp < 0) ? -ramp : ramp;
					if (mag > longint'({33'd0, shadow_ramp_limit})) begin
						off = (tgt * 655 + off * 64881) >>> 16;
						ramp = (ramp * 64881) / 65536;
					end
					slot_ramp_error[s] = ramp[31:0];
				end
			end
			slot_offset[s] = clamp_s32(off);
		end
		r.fuse_now = fuse;
		r.measurement_cm = clamp_s32(rd - longint'(slot_offset[s]));
		r.velocity_error = slot_vel_error[s];
		r.zero_offset = slot_offset[s];
		return r;
	endfunction

	function automatic sensor_item_t make_update(input logic [1:0] slot, input logic valid,
			input logic armed, input logic signed [31:0] reading, sens_vel, accel_vel, fused);
		sensor_item_t it;
		it.slot = slot;
		it.reading_valid = valid;
		it.armed = armed;
		it.reading_cm = reading;
		it.sensor_velocity = sens_vel;
		it.accel_velocity = accel_vel;
		it.fused_estimate = fused;
		return it;
	endfunction

	function automatic int spread(input int unsigned half);
		return int'($urandom_range(0, 2 * half)) - int'(half);
	endfunction

	// mostly plausible flight data with a drifting per-slot bias, some raw noise
	function automatic sensor_item_t random_update();
		sensor_item_t it;
		int s;
		int accel;
		s = $urandom_range(0, SLOTS - 1);
		it.slot = 2'(s);
		it.reading_valid = ($urandom_range(0, 9) != 0);
		it.armed = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 9) == 0) begin
			it.reading_cm = $urandom;
			it.sensor_velocity = $urandom;
			it.accel_velocity = $urandom;
			it.fused_estimate = $urandom;
		end else begin
			if ($urandom_range(0, 39) == 0) begin
				slot_drift[s] = spread(1 << 18);
			end else begin
				slot_drift[s] = slot_drift[s] + spread(4096);
			end
			it.fused_estimate = spread(1 << 21);
			it.reading_cm = it.fused_estimate + slot_drift[s] + spread(1024);
			accel = spread(1 << 20);
			it.accel_velocity = accel;
			case ($urandom_range(0, 3))
				0: it.sensor_velocity = accel + spread(1 << 10);
				1, 2: it.sensor_velocity = accel + spread(1 << 17);
				default: it.sensor_velocity = accel + spread(1 << 20);
			endcase
		end
		return it;
	endfunction

	// offer one item, predict on acceptance, then maybe leave a gap
	task automatic send_update(input sensor_item_t it);
		sensor_item <= it;
		sensor_valid <= 1'b1;
		@(posedge clk);
		while (sensor_stall) begin
			@(posedge clk);
		end
		fusion_results_due.push_back(qualify_update(it));
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 23);
			if ($urandom_range(0, 3) != 0) begin
				sensor_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// stop sending and wait for the pipeline to empty
	task automatic settle();
		sensor_valid <= 1'b0;
		while (fusion_results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (NUM_STAGES + 2) @(posedge clk);
	endtask

	// apb write: setup phase, access phase, then idle
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ERROR_THRESHOLD: shadow_threshold = val[15:0];
			REG_ERROR_CEILING: shadow_ceiling = val[15:0];
			REG_PENALTY_LENGTH: shadow_penalty_len = val[7:0];
			default: shadow_ramp_limit = val[30:0];
		endcase
		@(posedge clk);
	endtask

	// unused upper bits carry noise and must be dropped
	task automatic set_config(input logic [15:0] th, input logic [15:0] ce,
			input logic [7:0] pl, input logic [30:0] rl);
		settle();
		write_reg(REG_ERROR_THRESHOLD, {16'($urandom), th});
		write_reg(REG_ERROR_CEILING, {16'($urandom), ce});
		write_reg(REG_PENALTY_LENGTH, {24'($urandom), pl});
		write_reg(REG_RAMP_LIMIT, {1'($urandom), rl});
		settings_used++;
	endtask

	task automatic test_directed_cases();
		// invalid update on a cleared slot
		send_update(make_update(0, 0, 1, S32_MAX, 0, 0, 0));
		// disarmed blend from both ends of the reading range
		send_update(make_update(0, 1, 0, S32_MAX, 0, 0, 0));
		send_update(make_update(1, 1, 0, S32_MIN, 100, 100, 0));
		send_update(make_update(0, 1, 0, S32_MAX, -256, 256, S32_MAX));
		// widest velocity difference both ways, offset saturates high
		send_update(make_update(2, 1, 1, S32_MAX, S32_MIN, S32_MAX, S32_MIN));
		send_update(make_update(2, 1, 1, S32_MAX, S32_MAX, S32_MIN, S32_MIN));
		// measurement below range on an invalid update
		send_update(make_update(2, 0, 0, S32_MIN, 0, 0, 0));
		// penalised slot halving toward a negative target
		send_update(make_update(2, 1, 1, S32_MIN, 0, 0, S32_MAX));
		// measurement above range against a negative offset
		send_update(make_update(1, 0, 1, S32_MAX, 0, 0, 0));
		// offset error saturates and trips slow tracking, both signs
		repeat (3) send_update(make_update(3, 1, 1, S32_MAX, 0, 0, S32_MIN));
		repeat (3) send_update(make_update(3, 1, 1, S32_MIN, 0, 0, S32_MAX));
		// quiet armed updates and a moderate velocity error
		send_update(make_update(0, 1, 1, 0, 0, 0, 0));
		send_update(make_update(1, 1, 1, 32'sd1000, 32'sd0, 32'sd200000, 32'sd900));
		send_update(make_update(1, 1, 1, -32'sd1000, 32'sd200000, 32'sd0, -32'sd900));
		send_update(make_update(3, 0, 0, 0, S32_MAX, S32_MIN, S32_MAX));
		send_update(make_update(0, 1, 1, 32'sd70000, 32'sd5, 32'sd5, 32'sd1000));
		settle();
	endtask

	task automatic test_register_extremes();
		int phase;
		int n;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_config(16'hffff, 16'hffff, 8'd0, RAMP_MAX);
				1: set_config(16'd0, 16'hffff, 8'hff, 31'd0);
				2: set_config(16'd0, 16'hffff, 8'd0, 31'd0);
				3: set_config(16'hffff, 16'd0, 8'hff, RAMP_MAX);
				default: set_config(ERROR_THRESHOLD_RST, ERROR_CEILING_RST, PENALTY_LENGTH_RST,
					RAMP_LIMIT_RST);
			endcase
			// drive the offset error to both limits of its range
			repeat (3) send_update(make_update(3, 1, 1, S32_MAX, 0, 0, S32_MIN));
			repeat (3) send_update(make_update(3, 1, 1, S32_MIN, 0, 0, S32_MAX));
			for (n = 0; n < 40; n++) begin
				send_update(random_update());
			end
		end
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		logic [15:0] th;
		logic [15:0] ce;
		logic [7:0] pl;
		logic [30:0] rl;
		for (phase = 0; phase < 8; phase++) begin
			th = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(100, 3000));
			ce = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1000, 20000));
			pl = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
			rl = ($urandom_range(0, 4) == 0) ? 31'($urandom) :
				31'($urandom_range(1000, 1000000));
			set_config(th, ce, pl, rl);
			for (n = 0; n < 70; n++) begin
				// hold off mid-phase until every result is back
				if (phase == 3 && n == 35) begin
					settle();
				end
				send_update(random_update());
			end
		end
	endtask

	// result checking and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (fusion_results_due.size() == 0) begin
				errors++;
				$display("%0t: result item with nothing expected: %h", $time, result_item);
			end else begin
				want = fusion_results_due.pop_front();
				if (result_item.fuse_now !== want.fuse_now) begin
					errors++;
					$display("%0t: fuse_now expected %0b got %0b", $time, want.fuse_now,
						result_item.fuse_now);
				end
				if (result_item.measurement_cm !== want.measurement_cm) begin
					errors++;
					$display("%0t: measurement_cm expected %0d got %0d", $time,
						want.measurement_cm, result_item.measurement_cm);
				end
				if (result_item.velocity_error !== want.velocity_error) begin
					errors++;
					$display("%0t: velocity_error expected %0d got %0d", $time,
						want.velocity_error, result_item.velocity_error);
				end
				if (result_item.zero_offset !== want.zero_offset) begin
					errors++;
					$display("%0t: zero_offset expected %0d got %0d", $time,
						want.zero_offset, result_item.zero_offset);
				end
			end
		end
		stall_cycle++;
		if (stall_cycle % 128 == 0) begin
			stall_mode = $urandom_range(0, 3);
		end
		case (stall_mode)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= stall_cycle[2] & stall_cycle[0];
		endcase
	end

	initial begin
		int i;
		shadow_threshold = ERROR_THRESHOLD_RST;
		shadow_ceiling = ERROR_CEILING_RST;
		shadow_penalty_len = PENALTY_LENGTH_RST;
		shadow_ramp_limit = RAMP_LIMIT_RST;
		for (i = 0; i < SLOTS; i++) begin
			slot_vel_error[i] = '0;
			slot_penalty[i] = '0;
			slot_offset[i] = '0;
			slot_ramp_error[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_register_extremes();
		test_random_traffic();
		settle();
		$display("sent %0d sensor updates over %0d register settings, %0d results checked",
			items_sent, settings_used, results_seen);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#TIMEOUT_NS;
		$display("FAIL");
		$finish;
	end

endmodule
